[rtl/qpe_pkg.sv]
// ----------------------------------------------------------------------------
// qpe_pkg
// Types, character constants and token helpers shared by the quoted-printable
// encoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qpe_pkg;

  localparam logic [7:0] ChCr      = 8'd13;
  localparam logic [7:0] ChLf      = 8'd10;
  localparam logic [7:0] ChEq      = 8'd61;
  localparam logic [7:0] PrintLow  = 8'd32;
  localparam logic [7:0] PrintHigh = 8'd126;
  localparam logic [6:0] LimitReset = 7'd76;

  localparam int MaxChars = 12;
  localparam int TokChars = 6;
  localparam int CountW   = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_of_run;
    logic       stream_done;
  } out_item_t;

  // Characters of one token, including any soft break in front of it.
  typedef struct packed {
    logic [TokChars-1:0][7:0] chars;
    logic [2:0]               count;
    logic [6:0]               len;
  } token_t;

  // Every character caused by one input word, first character in entry 0.
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CountW-1:0]        count;
    logic                     done;
  } plan_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'd48 + {4'b0000, v};
    end else begin
      r = 8'd55 + {4'b0000, v};
    end
    return r;
  endfunction

  function automatic token_t make_token(input logic [7:0] b, input logic [6:0] len_in,
                                        input logic [6:0] limit);
    token_t     t;
    logic       esc;
    logic [7:0] tlen;
    logic [7:0] sum;
    logic       brk;
    t    = '0;
    esc  = (b < PrintLow) || (b > PrintHigh) || (b == ChEq);
    tlen = esc ? 8'd3 : 8'd1;
    sum  = {1'b0, len_in} + tlen;
    brk  = (len_in != 7'd0) && (sum >= {1'b0, limit});
    if (brk) begin
      t.chars[0] = ChEq;
      t.chars[1] = ChCr;
      t.chars[2] = ChLf;
      if (esc) begin
        t.chars[3] = ChEq;
        t.chars[4] = hex_char(b[7:4]);
        t.chars[5] = hex_char(b[3:0]);
        t.count    = 3'd6;
      end else begin
        t.chars[3] = b;
        t.count    = 3'd4;
      end
      t.len = tlen[6:0];
    end else begin
      if (esc) begin
        t.chars[0] = ChEq;
        t.chars[1] = hex_char(b[7:4]);
        t.chars[2] = hex_char(b[3:0]);
        t.count    = 3'd3;
      end else begin
        t.chars[0] = b;
        t.count    = 3'd1;
      end
      t.len = sum[6:0];
    end
    return t;
  endfunction

endpackage

[rtl/qpe_plan.sv]
// ----------------------------------------------------------------------------
// qpe_plan
// Works out every character that one input word causes, together with the
// next held-CR flag and line length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpe_plan (
  input  logic             held_cr,
  input  logic [6:0]       line_length,
  input  logic [6:0]       line_limit,
  input  qpe_pkg::in_item_t item,
  output qpe_pkg::plan_t   plan,
  output logic             held_cr_next,
  output logic [6:0]       line_length_next
);

  qpe_pkg::token_t first_tok;
  qpe_pkg::token_t second_tok;
  qpe_pkg::token_t cr_tok;
  qpe_pkg::token_t byte_tok;
  logic [6:0]      len_mid;
  logic            hard_break;
  logic            hold_now;
  logic [5:0]      shift_bits;

  assign hard_break = held_cr && (item.data_byte == qpe_pkg::ChLf);
  assign hold_now   = (item.data_byte == qpe_pkg::ChCr) && !item.end_of_data;

  assign cr_tok   = qpe_pkg::make_token(qpe_pkg::ChCr, line_length, line_limit);
  assign len_mid  = held_cr ? cr_tok.len : line_length;
  assign byte_tok = qpe_pkg::make_token(item.data_byte, len_mid, line_limit);

  always_comb begin
    first_tok  = held_cr ? cr_tok : '0;
    second_tok = hold_now ? '0 : byte_tok;
    shift_bits = {first_tok.count, 3'b000};
    plan       = '0;
    plan.done  = item.end_of_data;
    if (hard_break) begin
      plan.chars[0]    = qpe_pkg::ChCr;
      plan.chars[1]    = qpe_pkg::ChLf;
      plan.count       = qpe_pkg::CountW'(2);
      held_cr_next     = 1'b0;
      line_length_next = 7'd0;
    end else begin
      plan.chars = (8*qpe_pkg::MaxChars)'(first_tok.chars)
                 | ((8*qpe_pkg::MaxChars)'(second_tok.chars) << shift_bits);
      plan.count = {1'b0, first_tok.count} + {1'b0, second_tok.count};
      held_cr_next     = hold_now;
      line_length_next = hold_now ? len_mid : byte_tok.len;
    end
    // The final word of a stream leaves a clean state for the next one.
    if (item.end_of_data) begin
      held_cr_next     = 1'b0;
      line_length_next = 7'd0;
    end
  end

endmodule

[rtl/qpe_emit.sv]
// ----------------------------------------------------------------------------
// qpe_emit
// Character buffer that shifts out one encoded character per accepted output
// word and flags the last character of each run and of the stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpe_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  qpe_pkg::plan_t     plan,
  output logic               load_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output qpe_pkg::out_item_t out_data
);

  logic [qpe_pkg::MaxChars-1:0][7:0] buffer;
  logic [qpe_pkg::CountW-1:0]        cnt;
  logic                              done_flag;

  assign out_valid = (cnt != '0);
  assign load_ok   = (cnt == '0) || ((cnt == qpe_pkg::CountW'(1)) && out_ready);

  assign out_data.text_byte   = buffer[0];
  assign out_data.last_of_run = (cnt == qpe_pkg::CountW'(1));
  assign out_data.stream_done = (cnt == qpe_pkg::CountW'(1)) && done_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= plan.count;
    end else if (out_valid && out_ready) begin
      cnt <= cnt - qpe_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buffer    <= plan.chars;
      done_flag <= plan.done;
    end else if (out_valid && out_ready) begin
      buffer <= buffer >> 8;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= qpe_pkg::CountW'(qpe_pkg::MaxChars))
    else $error("character count beyond buffer depth");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> (cnt == $past(plan.count)))
    else $error("loaded run length not taken");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> load_ok)
    else $error("run loaded over characters still pending");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.stream_done |-> out_data.last_of_run)
    else $error("stream end flagged before end of run");
`endif

endmodule

[rtl/quoted_printable_encoder_unit.sv]
// ----------------------------------------------------------------------------
// quoted_printable_encoder_unit
// A word's first character is offered once it has passed the input register
// and been loaded into the output buffer, which sends one character per cycle
// while out_ready is high. A word yields 1 to 12 characters, a held CR none.
// Reset clears the held CR and the line length and sets line_limit to 76.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quoted_printable_encoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qpe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qpe_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data
);

  logic              a_valid;
  qpe_pkg::in_item_t a_item;
  logic              held_cr;
  logic              held_cr_next;
  logic [6:0]        line_length;
  logic [6:0]        line_length_next;
  logic [6:0]        line_limit;
  qpe_pkg::plan_t    plan;
  logic              load_ok;
  logic              load;
  logic              a_consume;

  // A word with nothing to emit (a held CR) leaves without waiting on output.
  assign a_consume = a_valid && ((plan.count == '0) || load_ok);
  assign load      = a_valid && (plan.count != '0) && load_ok;
  assign in_ready  = !a_valid || a_consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cr     <= 1'b0;
      line_length <= 7'd0;
    end else if (a_consume) begin
      held_cr     <= held_cr_next;
      line_length <= line_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= qpe_pkg::LimitReset;
    end else if (cfg_we) begin
      line_limit <= cfg_data;
    end
  end

  qpe_plan u_plan (
    .held_cr          (held_cr),
    .line_length      (line_length),
    .line_limit       (line_limit),
    .item             (a_item),
    .plan             (plan),
    .held_cr_next     (held_cr_next),
    .line_length_next (line_length_next)
  );

  qpe_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .plan      (plan),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    a_consume && a_item.end_of_data |=> !held_cr && (line_length == 7'd0))
    else $error("state not cleared after final word");

  // A CR that is newly held emits nothing when no earlier CR was waiting.
  a_hold_silent: assert property (@(posedge clk) disable iff (rst)
    a_consume && held_cr_next && !held_cr |-> !load)
    else $error("held CR produced characters");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_consume |=> a_valid && $stable(a_item))
    else $error("pending word lost from input register");
`endif

endmodule
